// File: rtl/assert_macros.svh
// assertion macros shared by the splitter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/uts_pkg.sv
// package: codes, job descriptor and chunk helpers of the transfer splitter
package uts_pkg;

	localparam int LENGTH_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 4;
	// widest length the job descriptor carries
	localparam int CNT_MAX_W        = 32;

	// address alignment bits
	localparam logic [1:0] ADDR_HALF_BIT = 2'h1;
	localparam logic [1:0] ADDR_WORD_BIT = 2'h2;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_WDATA = 2'd1,
		REQ_COMPL = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ERASE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_RD_CMD  = 2'd0,
		KIND_WR_CMD  = 2'd1,
		KIND_RD_BYTE = 2'd2,
		KIND_DONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2
	} asize_t;

	// one unit of back-end work: read bytes, then a command, then done
	typedef struct packed {
		logic [2:0]           nbytes;
		logic [31:0]          rdata;
		logic                 cmd_v;
		kind_t                cmd_kind;
		asize_t               cmd_size;
		logic [31:0]          cmd_addr;
		logic [31:0]          cmd_word;
		logic                 done_v;
		logic [CNT_MAX_W-1:0] done_cnt;
	} job_t;

	// next access size in bytes from alignment and what is left
	function automatic logic [2:0] pick_chunk(input logic [1:0] addr_lo, input logic ge2,
			input logic ge4);
		logic [2:0] c;
		if ((addr_lo & ADDR_HALF_BIT) != 2'd0) begin
			c = 3'd1;
		end else if (ge2 && ((addr_lo & ADDR_WORD_BIT) != 2'd0)) begin
			c = 3'd2;
		end else if (ge4) begin
			c = 3'd4;
		end else if (ge2) begin
			c = 3'd2;
		end else begin
			c = 3'd1;
		end
		return c;
	endfunction

	function automatic asize_t size_code(input logic [2:0] chunk);
		asize_t s;
		if (chunk == 3'd4) begin
			s = SIZE_WORD;
		end else if (chunk == 3'd2) begin
			s = SIZE_HALF;
		end else begin
			s = SIZE_BYTE;
		end
		return s;
	endfunction

endpackage

// File: rtl/uts_front.sv
// front end: accepts requests, tracks transfer state and queues jobs
`include "assert_macros.svh"

module uts_front import uts_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    q_full,
	input  logic [1:0]              req_type,
	input  logic [1:0]              operation,
	input  logic [31:0]             start_address,
	input  logic [LENGTH_WIDTH-1:0] byte_count,
	input  logic [7:0]              data_byte,
	input  logic [31:0]             read_data,
	output logic                    q_push,
	output job_t                    q_job
);

	logic                    busy_q, busy_d;
	op_t                     mode_q, mode_d;
	logic [31:0]             addr_q, addr_d;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
	logic [LENGTH_WIDTH-1:0] total_q, total_d;
	logic [2:0]              chunk_q, chunk_d;
	logic [2:0]              held_q, held_d;
	logic [31:0]             pack_q, pack_d;

	logic                    accept;
	logic                    op_ok;
	logic [2:0]              st_chunk;
	logic [31:0]             adv_addr;
	logic [LENGTH_WIDTH-1:0] adv_rem;
	logic [2:0]              adv_chunk;
	logic [2:0]              held_inc;
	logic [31:0]             pack_new;
	logic                    do_adv;
	job_t                    job_d;
	logic                    job_v;

	assign accept = push && !q_full;
	assign op_ok  = (operation == OP_READ) || (operation == OP_WRITE) ||
		(operation == OP_ERASE);

	// alignment arithmetic for a new transfer and for stepping past a chunk
	assign st_chunk  = pick_chunk(start_address[1:0], byte_count >= LENGTH_WIDTH'(2),
		byte_count >= LENGTH_WIDTH'(4));
	assign adv_addr  = addr_q + 32'(chunk_q);
	assign adv_rem   = rem_q - LENGTH_WIDTH'(chunk_q);
	assign adv_chunk = pick_chunk(adv_addr[1:0], adv_rem >= LENGTH_WIDTH'(2),
		adv_rem >= LENGTH_WIDTH'(4));
	assign held_inc  = held_q + 3'd1;
	assign pack_new  = pack_q | (32'(data_byte) << {held_q[1:0], 3'b000});

	// request decode and next state
	always_comb begin
		busy_d  = busy_q;
		mode_d  = mode_q;
		addr_d  = addr_q;
		rem_d   = rem_q;
		total_d = total_q;
		chunk_d = chunk_q;
		held_d  = held_q;
		pack_d  = pack_q;
		job_d   = '0;
		job_v   = 1'b0;
		do_adv  = 1'b0;
		if (accept) begin
			unique case (req_type)
				REQ_START: begin
					if (op_ok) begin
						mode_d  = op_t'(operation);
						addr_d  = start_address;
						rem_d   = byte_count;
						total_d = byte_count;
						held_d  = 3'd0;
						pack_d  = 32'd0;
						if (byte_count == '0) begin
							busy_d        = 1'b0;
							chunk_d       = 3'd0;
							job_v         = 1'b1;
							job_d.done_v  = 1'b1;
						end else begin
							busy_d         = 1'b1;
							chunk_d        = st_chunk;
							job_d.cmd_addr = start_address;
							job_d.cmd_size = size_code(st_chunk);
							if (operation == OP_READ) begin
								job_v          = 1'b1;
								job_d.cmd_v    = 1'b1;
								job_d.cmd_kind = KIND_RD_CMD;
							end else if (operation == OP_ERASE) begin
								job_v          = 1'b1;
								job_d.cmd_v    = 1'b1;
								job_d.cmd_kind = KIND_WR_CMD;
							end
						end
					end
				end
				REQ_WDATA: begin
					if (busy_q && mode_q == OP_WRITE) begin
						pack_d = pack_new;
						held_d = held_inc;
						if (held_inc >= chunk_q) begin
							job_v          = 1'b1;
							job_d.cmd_v    = 1'b1;
							job_d.cmd_kind = KIND_WR_CMD;
							job_d.cmd_addr = addr_q;
							job_d.cmd_size = size_code(chunk_q);
							job_d.cmd_word = pack_new;
							do_adv         = 1'b1;
						end
					end
				end
				REQ_COMPL: begin
					if (busy_q && mode_q != OP_WRITE) begin
						if (mode_q == OP_READ) begin
							job_d.nbytes = chunk_q;
							job_d.rdata  = read_data;
						end
						do_adv = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// step past the finished chunk: done or the next access
		if (do_adv) begin
			addr_d = adv_addr;
			rem_d  = adv_rem;
			pack_d = 32'd0;
			held_d = 3'd0;
			job_v  = 1'b1;
			if (adv_rem == '0) begin
				busy_d         = 1'b0;
				chunk_d        = 3'd0;
				job_d.done_v   = 1'b1;
				job_d.done_cnt = CNT_MAX_W'(total_q);
			end else begin
				chunk_d = adv_chunk;
				if (mode_q != OP_WRITE) begin
					job_d.cmd_v    = 1'b1;
					job_d.cmd_kind = (mode_q == OP_READ) ? KIND_RD_CMD : KIND_WR_CMD;
					job_d.cmd_addr = adv_addr;
					job_d.cmd_size = size_code(adv_chunk);
				end
			end
		end
	end

	assign q_push = job_v;
	assign q_job  = job_d;

	// transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			mode_q  <= OP_READ;
			addr_q  <= 32'd0;
			rem_q   <= '0;
			total_q <= '0;
			chunk_q <= 3'd0;
			held_q  <= 3'd0;
			pack_q  <= 32'd0;
		end else begin
			busy_q  <= busy_d;
			mode_q  <= mode_d;
			addr_q  <= addr_d;
			rem_q   <= rem_d;
			total_q <= total_d;
			chunk_q <= chunk_d;
			held_q  <= held_d;
			pack_q  <= pack_d;
		end
	end

	`ASSERT_IMP(a_busy_has_work, clk, arst_n, busy_q, (chunk_q != 3'd0) && (rem_q != '0))

endmodule

// File: rtl/uts_queue.sv
// job queue between front end and back end
`include "assert_macros.svh"

module uts_queue import uts_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output job_t rdata,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_IMP(a_cnt_in_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`ASSERT_NXT(a_push_fills, clk, arst_n, do_push && !do_pop, !empty)

endmodule

// File: rtl/uts_back.sv
// back end: expands queued jobs into results, one per cycle while each result is popped
`include "assert_macros.svh"

module uts_back import uts_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  job_t                    q_job,
	input  logic                    q_empty,
	output logic                    q_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              result_kind,
	output logic [31:0]             bus_address,
	output logic [1:0]              access_size,
	output logic [31:0]             write_word,
	output logic [7:0]              out_byte,
	output logic [LENGTH_WIDTH-1:0] moved_count,
	output logic                    last
);

	logic                    out_v_q;
	logic [2:0]              idx_q;
	kind_t                   kind_q;
	logic [31:0]             addr_q;
	asize_t                  size_q;
	logic [31:0]             word_q;
	logic [7:0]              byte_q;
	logic [LENGTH_WIDTH-1:0] cnt_q;
	logic                    last_q;

	logic                    load;
	logic [2:0]              njobres;
	logic                    is_byte;
	logic                    is_cmd;
	logic                    is_last;
	kind_t                   kind_n;
	logic [31:0]             addr_n;
	asize_t                  size_n;
	logic [31:0]             word_n;
	logic [7:0]              byte_n;
	logic [LENGTH_WIDTH-1:0] cnt_n;

	// output register refills when empty or when its transfer completes
	assign load    = !q_empty && (!out_v_q || pop);
	assign njobres = q_job.nbytes + {2'b00, q_job.cmd_v} + {2'b00, q_job.done_v};
	assign is_byte = idx_q < q_job.nbytes;
	assign is_cmd  = !is_byte && q_job.cmd_v && (idx_q == q_job.nbytes);
	assign is_last = (idx_q == njobres - 3'd1);
	assign q_pop   = load && is_last;

	// select the result at the current position in the job
	always_comb begin
		addr_n = 32'd0;
		size_n = SIZE_BYTE;
		word_n = 32'd0;
		byte_n = 8'd0;
		cnt_n  = '0;
		if (is_byte) begin
			kind_n = KIND_RD_BYTE;
			byte_n = q_job.rdata[{idx_q[1:0], 3'b000} +: 8];
		end else if (is_cmd) begin
			kind_n = q_job.cmd_kind;
			addr_n = q_job.cmd_addr;
			size_n = q_job.cmd_size;
			word_n = q_job.cmd_word;
		end else begin
			kind_n = KIND_DONE;
			cnt_n  = q_job.done_cnt[LENGTH_WIDTH-1:0];
		end
	end

	// valid flag and position within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= 3'd0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_n;
			addr_q <= addr_n;
			size_q <= size_n;
			word_q <= word_n;
			byte_q <= byte_n;
			cnt_q  <= cnt_n;
			last_q <= is_last;
		end
	end

	assign empty       = !out_v_q;
	assign result_kind = kind_q;
	assign bus_address = addr_q;
	assign access_size = size_q;
	assign write_word  = word_q;
	assign out_byte    = byte_q;
	assign moved_count = cnt_q;
	assign last        = last_q;

	`ASSERT_IMP(a_mid_job_has_head, clk, arst_n, idx_q != 3'd0, !q_empty)

endmodule

// File: rtl/unaligned_transfer_splitter_unit.sv
// Unaligned transfer splitter: turns start, write-byte and completion requests into bus
// commands, read bytes and done results. The input side takes one request per cycle while
// the job queue has room; each request becomes at most one job holding up to five results
// (a read completion gives up to four bytes plus the next command or done). The result side
// delivers one result per cycle while each result is popped, so the output transfer rate
// sets sustained throughput. An accepted request's job goes into the queue and then into
// the output register before its first result shows. The queue holds QUEUE_DEPTH jobs
// (at least 2); LENGTH_WIDTH (8 to 32) sets the width of byte_count and moved_count.

module unaligned_transfer_splitter_unit import uts_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              req_type,
	input  logic [1:0]              operation,
	input  logic [31:0]             start_address,
	input  logic [LENGTH_WIDTH-1:0] byte_count,
	input  logic [7:0]              data_byte,
	input  logic [31:0]             read_data,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              result_kind,
	output logic [31:0]             bus_address,
	output logic [1:0]              access_size,
	output logic [31:0]             write_word,
	output logic [7:0]              out_byte,
	output logic [LENGTH_WIDTH-1:0] moved_count,
	output logic                    last
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t job_in;
	job_t job_head;

	assign full = q_full;

	// request decode and transfer state
	uts_front #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (q_full),
		.req_type     (req_type),
		.operation    (operation),
		.start_address(start_address),
		.byte_count   (byte_count),
		.data_byte    (data_byte),
		.read_data    (read_data),
		.q_push       (q_push),
		.q_job        (job_in)
	);

	// decoupling queue
	uts_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (job_in),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (job_head),
		.empty (q_empty)
	);

	// result sequencing
	uts_back #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_job      (job_head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result_kind(result_kind),
		.bus_address(bus_address),
		.access_size(access_size),
		.write_word (write_word),
		.out_byte   (out_byte),
		.moved_count(moved_count),
		.last       (last)
	);

endmodule
